### rtl/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] NONE_VAL = 32'hFFFF_FFFF;  // -1 when nothing greater

  typedef struct packed {
    logic signed [31:0] price;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] span;
    logic signed [31:0] prev_greater;
    logic               found;
    logic               lost;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch accepted item, apply restart
    logic pop;     // drop top, fetch the entry below
    logic refill;  // top cache <- fetched entry
    logic finish;  // emit result, push item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_needed;  // stack not empty and top <= price
    logic out_busy;    // result register full and not taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/ssp_if.sv
`default_nettype none

interface ssp_in_if;
  import ssp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ssp_out_if;
  import ssp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ssp_ctrl.sv
`default_nettype none

module ssp_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ssp_pkg::dp_status_t status_i,
  output ssp_pkg::dp_cmd_t    cmd_o
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.pop_needed) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_WAIT;
        end else if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_WAIT: begin
        cmd_o.refill = 1'b1;
        state_d      = ST_CMP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_pop_then_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> cmd_o.refill)
    else $error("pop not followed by refill");

  a_load_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CMP))
    else $error("accepted item did not enter compare");

  a_finish_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !status_i.out_busy && !status_i.pop_needed)
    else $error("finish while pop pending or result register busy");

endmodule

`default_nettype wire

### rtl/ssp_dp.sv
`default_nettype none

module ssp_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ssp_pkg::in_item_t   in_item_i,
  input  ssp_pkg::dp_cmd_t    cmd_i,
  output ssp_pkg::dp_status_t status_o,
  ssp_out_if.source           out_o
);
  import ssp_pkg::*;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(STACK_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(STACK_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // stack storage, circular so that dropping the bottom entry is a pointer move
  logic signed [31:0] mem_val [STACK_DEPTH];
  logic        [31:0] mem_pos [STACK_DEPTH];
  logic signed [31:0] rd_val_q;
  logic        [31:0] rd_pos_q;

  logic [PTR_W-1:0]   top_q;
  logic [CNT_W-1:0]   count_q;
  logic [31:0]        pos_q;
  logic               lost_q;
  logic signed [31:0] price_q;
  logic signed [31:0] top_val_q;
  logic        [31:0] top_pos_q;

  logic               out_valid_q;
  out_item_t          out_q;

  logic               full;
  logic [PTR_W-1:0]   top_dec, top_inc;
  out_item_t          res;

  assign full    = (count_q == CNT_W'(STACK_DEPTH));
  assign top_dec = ptr_dec(top_q);
  assign top_inc = ptr_inc(top_q);

  assign status_o.pop_needed = (count_q != '0) && (top_val_q <= price_q);
  assign status_o.out_busy   = out_valid_q && !out_o.ready;

  always_comb begin
    res = '0;
    if (count_q == '0) begin
      res.span         = (pos_q == POS_MAX) ? POS_MAX : pos_q + 32'd1;
      res.prev_greater = NONE_VAL;
      res.found        = 1'b0;
    end else begin
      res.span         = (pos_q > top_pos_q) ? pos_q - top_pos_q : 32'd1;
      res.prev_greater = top_val_q;
      res.found        = 1'b1;
    end
    res.lost = lost_q || full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= PTR_W'(STACK_DEPTH - 1);
      count_q <= '0;
      pos_q   <= '0;
      lost_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (in_item_i.restart) begin
        top_q   <= PTR_W'(STACK_DEPTH - 1);
        count_q <= '0;
        pos_q   <= '0;
        lost_q  <= 1'b0;
      end
    end else if (cmd_i.pop) begin
      top_q   <= top_dec;
      count_q <= count_q - CNT_W'(1);
    end else if (cmd_i.finish) begin
      top_q <= top_inc;
      if (full) begin
        lost_q <= 1'b1;  // push overwrites the oldest entry
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
      if (pos_q != POS_MAX) begin
        pos_q <= pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q <= in_item_i.price;
    end
    if (cmd_i.refill) begin
      top_val_q <= rd_val_q;
      top_pos_q <= rd_pos_q;
    end else if (cmd_i.finish) begin
      top_val_q <= price_q;
      top_pos_q <= pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mem_val[top_inc] <= price_q;
      mem_pos[top_inc] <= pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_val_q <= mem_val[top_dec];
    rd_pos_q <= mem_pos[top_dec];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop on empty stack");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q && (count_q != '0))
    else $error("result or push missing after finish");

  a_lost_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && full) |=> lost_q && out_q.lost)
    else $error("overflow not flagged");

endmodule

`default_nettype wire

### rtl/stock_span_previous_greater.sv
// Channel  Dir  Payload                                  Transfer
// in_i     in   price (s32), restart (1)                 valid & ready
// out_o    out  span (u32), prev_greater (s32), found,   valid & ready
//               lost
//
// An item is loaded, then compared; a refill follows each pop (memory read is
// registered, one entry fetched per pop); pops average at most one per item.
// The result register lets the next item be accepted while a result waits.
// Reset clears counters and flags; the stack memory is not cleared.
// A stalled output only holds the block when the next result is ready.
`default_nettype none

module stock_span_previous_greater (
  input  wire       clk_i,
  input  wire       rst_ni,
  ssp_in_if.sink    in_i,
  ssp_out_if.source out_o
);
  import ssp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_i.payload),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
